@@ rtl/core/imu_pp_pkg.sv @@
package imu_pp_pkg;

    localparam int PKT_MAX   = 20;
    localparam int POS_W     = 5;
    localparam int AXIS_W    = 20;
    localparam int TDATA_W   = 160;
    localparam int TUSER_W   = 4;

    localparam logic [POS_W-1:0] LEN_SHORT = 5'd8;
    localparam logic [POS_W-1:0] LEN_MID   = 5'd16;
    localparam logic [POS_W-1:0] LEN_LONG  = 5'd20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HDR  = 2'd1;
    localparam logic [1:0] ST_RSVD_TS  = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    localparam logic [1:0] KIND_ACCEL  = 2'd0;
    localparam logic [1:0] KIND_GYRO   = 2'd1;
    localparam logic [1:0] KIND_BOTH   = 2'd2;
    localparam logic [1:0] KIND_HIRES  = 2'd3;

    localparam logic [1:0] TS_MODE_RSVD = 2'b01;

    typedef logic [PKT_MAX-1:0][7:0] chain_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic [3:0] flags;
    } evt_t;

endpackage

@@ rtl/core/imu_pp_cell.sv @@
module imu_pp_cell (
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= d;
        end
    end

    assign q = byte_reg;

endmodule

@@ rtl/core/imu_pp_ctrl.sv @@
module imu_pp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              evt_take,
    output imu_pp_pkg::evt_t  evt,
    output logic              evt_valid
);

    import imu_pp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [1:0]       kind_reg, kind_next;
    logic             disc_reg, disc_next;
    logic [3:0]       flags_reg, flags_next;
    evt_t             evt_reg, evt_next;
    logic             evt_valid_reg, evt_valid_next;

    logic             msg, acc, gyr, hr;
    logic [POS_W-1:0] pos_inc;
    logic             new_evt;
    evt_t             new_item;

    assign msg     = data_byte[7];
    assign acc     = data_byte[6];
    assign gyr     = data_byte[5];
    assign hr      = data_byte[4];
    assign pos_inc = pos_reg + 5'd1;

    always_comb begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        disc_next  = disc_reg;
        flags_next = flags_reg;
        new_evt    = 1'b0;
        new_item   = '0;
        if (accept) begin
            if (disc_reg) begin
                if (last_byte) begin
                    disc_next = 1'b0;
                    pos_next  = '0;
                end
            end else if (pos_reg == '0) begin
                if (msg || (!acc && !gyr) || (hr && !(acc && gyr))) begin
                    new_evt         = 1'b1;
                    new_item.status = ST_BAD_HDR;
                    disc_next       = !last_byte;
                end else begin
                    if (acc && gyr) begin
                        kind_next = hr ? KIND_HIRES : KIND_BOTH;
                        len_next  = hr ? LEN_LONG : LEN_MID;
                    end else begin
                        kind_next = acc ? KIND_ACCEL : KIND_GYRO;
                        len_next  = LEN_SHORT;
                    end
                    flags_next = data_byte[3:0];
                    pos_next   = 5'd1;
                    if (last_byte) begin
                        new_evt         = 1'b1;
                        new_item.status = ST_TRUNC;
                        new_item.kind   = kind_next;
                        new_item.flags  = data_byte[3:0];
                        pos_next        = '0;
                    end
                end
            end else begin
                pos_next       = pos_inc;
                new_item.kind  = kind_reg;
                new_item.flags = flags_reg;
                if (pos_inc >= len_reg) begin
                    new_evt  = 1'b1;
                    pos_next = '0;
                    if (flags_reg[3:2] == TS_MODE_RSVD) begin
                        new_item.status = ST_RSVD_TS;
                        disc_next       = !last_byte;
                    end else begin
                        new_item.status = ST_OK;
                    end
                end else if (last_byte) begin
                    new_evt         = 1'b1;
                    new_item.status = ST_TRUNC;
                    pos_next        = '0;
                end
            end
        end
        evt_next       = new_evt ? new_item : evt_reg;
        evt_valid_next = new_evt ? 1'b1 : (evt_take ? 1'b0 : evt_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            len_reg       <= '0;
            kind_reg      <= '0;
            disc_reg      <= 1'b0;
            flags_reg     <= '0;
            evt_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            kind_reg      <= kind_next;
            disc_reg      <= disc_next;
            flags_reg     <= flags_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        evt_reg <= evt_next;
    end

    assign evt       = evt_reg;
    assign evt_valid = evt_valid_reg;

endmodule

@@ rtl/core/imu_pp_decode.sv @@
module imu_pp_decode (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  imu_pp_pkg::chain_t                 cells,
    input  imu_pp_pkg::evt_t                   evt,
    input  logic                               evt_valid,
    output logic                               evt_take,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [imu_pp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [imu_pp_pkg::TUSER_W-1:0]     m_tuser
);

    import imu_pp_pkg::*;

    logic                 tvalid_reg, tvalid_next;
    logic [TDATA_W-1:0]   tdata_reg, tdata_next;
    logic [TUSER_W-1:0]   tuser_reg, tuser_next;

    logic [AXIS_W-1:0] ax, ay, az, gx, gy, gz;
    logic [15:0]       temp, ts;

    // newest byte sits in cell 0: byte i of an n-byte packet is in cell n-1-i
    function automatic logic [AXIS_W-1:0] axis16(input logic [7:0] hi, input logic [7:0] lo);
        axis16 = {{4{hi[7]}}, hi, lo};
    endfunction

    function automatic logic [AXIS_W-1:0] axis20(input logic [7:0] hi, input logic [7:0] lo,
                                                 input logic [3:0] nib);
        axis20 = {hi, lo, nib};
    endfunction

    always_comb begin
        ax   = '0;
        ay   = '0;
        az   = '0;
        gx   = '0;
        gy   = '0;
        gz   = '0;
        temp = '0;
        ts   = '0;
        if (evt.status == ST_OK) begin
            case (evt.kind)
                KIND_ACCEL: begin
                    ax   = axis16(cells[6], cells[5]);
                    ay   = axis16(cells[4], cells[3]);
                    az   = axis16(cells[2], cells[1]);
                    temp = {{8{cells[0][7]}}, cells[0]};
                end
                KIND_GYRO: begin
                    gx   = axis16(cells[6], cells[5]);
                    gy   = axis16(cells[4], cells[3]);
                    gz   = axis16(cells[2], cells[1]);
                    temp = {{8{cells[0][7]}}, cells[0]};
                end
                KIND_BOTH: begin
                    ax   = axis16(cells[14], cells[13]);
                    ay   = axis16(cells[12], cells[11]);
                    az   = axis16(cells[10], cells[9]);
                    gx   = axis16(cells[8], cells[7]);
                    gy   = axis16(cells[6], cells[5]);
                    gz   = axis16(cells[4], cells[3]);
                    temp = {{8{cells[2][7]}}, cells[2]};
                    ts   = {cells[1], cells[0]};
                end
                default: begin
                    ax   = axis20(cells[18], cells[17], cells[2][7:4]);
                    ay   = axis20(cells[16], cells[15], cells[1][7:4]);
                    az   = axis20(cells[14], cells[13], cells[0][7:4]);
                    gx   = axis20(cells[12], cells[11], cells[2][3:0]);
                    gy   = axis20(cells[10], cells[9], cells[1][3:0]);
                    gz   = axis20(cells[8], cells[7], cells[0][3:0]);
                    temp = {cells[6], cells[5]};
                    ts   = {cells[4], cells[3]};
                end
            endcase
        end
    end

    assign evt_take = evt_valid && (!tvalid_reg || m_tready);

    always_comb begin
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        tuser_next  = tuser_reg;
        if (evt_take) begin
            tvalid_next = 1'b1;
            tdata_next  = {4'd0, evt.flags, ts, temp, gz, gy, gx, az, ay, ax};
            tuser_next  = {evt.kind, evt.status};
        end else if (m_tready) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

@@ rtl/core/imu_fifo_packet_parser_top.sv @@
// A result passes the event register and then the output register before it shows on m_tvalid.
// One byte per cycle when not stalled; each byte shifts one place along a 20-cell byte chain.
// The decode taps read the chain while the finished item waits, before the next shift.
// Stall: input is held only when a finished item and the output register are both occupied.
// Reset (aresetn low, synchronous) clears parser control and output valid; the chain is not reset.
module imu_fifo_packet_parser_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] data_byte
    input  logic                               s_tlast,  // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [19:0] accel_x, [39:20] accel_y, [59:40] accel_z, [79:60] gyro_x,
    // [99:80] gyro_y, [119:100] gyro_z, [135:120] temperature_raw,
    // [151:136] timestamp, [155:152] header_flags, [159:156] zero
    output logic [imu_pp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [imu_pp_pkg::TUSER_W-1:0]     m_tuser   // [1:0] status, [3:2] packet_kind
);

    import imu_pp_pkg::*;

    chain_t cells;
    evt_t   evt;
    logic   evt_valid;
    logic   evt_take;
    logic   accept;

    assign s_tready = !evt_valid || evt_take;
    assign accept   = s_tvalid && s_tready;

    genvar k;
    generate
        for (k = 0; k < PKT_MAX; k++) begin : g_cell
            if (k == 0) begin : g_head
                imu_pp_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (accept),
                    .d        (s_tdata),
                    .q        (cells[k])
                );
            end else begin : g_body
                imu_pp_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (accept),
                    .d        (cells[k-1]),
                    .q        (cells[k])
                );
            end
        end
    endgenerate

    imu_pp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .evt_take  (evt_take),
        .evt       (evt),
        .evt_valid (evt_valid)
    );

    imu_pp_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cells     (cells),
        .evt       (evt),
        .evt_valid (evt_valid),
        .evt_take  (evt_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ sim/tb_imu_fifo_packet_parser_top.sv @@
`timescale 1ns / 1ps

module tb_imu_fifo_packet_parser_top;

    import imu_pp_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        kind;
        logic [2:0][19:0]  acc;
        logic [2:0][19:0]  gyr;
        logic [15:0]       temp;
        logic [15:0]       ts;
        logic [3:0]        flags;
    } imu_res_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        logic [1:0] status;
        logic [1:0] kind;
        logic [3:0] flags;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;

    imu_fifo_packet_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser shadow state
    logic [7:0]   pkt_buf [PKT_MAX];
    int unsigned  pkt_pos  = 0;
    int unsigned  pkt_len  = 0;
    logic [1:0]   cur_kind = KIND_ACCEL;
    bit           dropping = 1'b0;

    imu_res_t     exp_q [$];
    int           n_sent   = 0;
    int           n_parsed = 0;
    int           n_err    = 0;

    // header errors, truncation on the header and mid-packet, then an extreme hi-res packet
    stim_row_t dir_tab [27] = '{
        '{8'h80, 1'b0, 1'b1, ST_BAD_HDR, KIND_ACCEL, 4'h0},
        '{8'hAA, 1'b1, 1'b0, ST_OK,      KIND_ACCEL, 4'h0},
        '{8'h0C, 1'b1, 1'b1, ST_BAD_HDR, KIND_ACCEL, 4'h0},
        '{8'h30, 1'b1, 1'b1, ST_BAD_HDR, KIND_ACCEL, 4'h0},
        '{8'h4F, 1'b1, 1'b1, ST_TRUNC,   KIND_ACCEL, 4'hF},
        '{8'h27, 1'b0, 1'b0, ST_OK,      KIND_GYRO,  4'h7},
        '{8'hFF, 1'b1, 1'b1, ST_TRUNC,   KIND_GYRO,  4'h7},
        '{8'h73, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h80, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h00, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h7F, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'hFF, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'hFF, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'hFF, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h00, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h00, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h80, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h00, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h7F, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'hFF, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h80, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h00, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'hFF, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'hFF, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h0F, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'hF0, 1'b0, 1'b0, ST_OK,      KIND_HIRES, 4'h3},
        '{8'h5A, 1'b1, 1'b0, ST_OK,      KIND_HIRES, 4'h3}
    };

    function automatic logic [15:0] be16(int unsigned i);
        return {pkt_buf[i], pkt_buf[i+1]};
    endfunction

    function automatic logic [19:0] axis16(int unsigned i);
        logic [15:0] v;
        v = be16(i);
        return {{4{v[15]}}, v};
    endfunction

    function automatic logic [19:0] axis20(int unsigned i, logic [3:0] nib);
        return {pkt_buf[i], pkt_buf[i+1], nib};
    endfunction

    function automatic logic [15:0] temp8(int unsigned i);
        return {{8{pkt_buf[i][7]}}, pkt_buf[i]};
    endfunction

    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit quiet_phase();
        return n_sent >= 500 && n_sent < 800;
    endfunction

    task automatic flag_mismatch(string fld, longint got, longint want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, fld, got, want);
        n_err++;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic lst,
                              output bit has_res, output imu_res_t r);
        logic msg, acc, gyr, hr;
        logic [7:0] ext;
        r = '0;
        has_res = 1'b0;
        if (dropping) begin
            if (lst) begin
                dropping = 1'b0;
                pkt_pos = 0;
            end
            return;
        end
        n_parsed++;
        if (pkt_pos == 0) begin
            msg = b[7];
            acc = b[6];
            gyr = b[5];
            hr  = b[4];
            if (msg || (!acc && !gyr) || (hr && !(acc && gyr))) begin
                r.status = ST_BAD_HDR;
                dropping = !lst;
                has_res = 1'b1;
                return;
            end
            if (acc && gyr) begin
                cur_kind = hr ? KIND_HIRES : KIND_BOTH;
                pkt_len  = 32'(hr ? LEN_LONG : LEN_MID);
            end else begin
                cur_kind = acc ? KIND_ACCEL : KIND_GYRO;
                pkt_len  = 32'(LEN_SHORT);
            end
            pkt_buf[0] = b;
            pkt_pos = 1;
            if (lst) begin
                r.status = ST_TRUNC;
                r.kind = cur_kind;
                r.flags = b[3:0];
                pkt_pos = 0;
                has_res = 1'b1;
            end
            return;
        end
        pkt_buf[pkt_pos] = b;
        pkt_pos++;
        r.kind = cur_kind;
        r.flags = pkt_buf[0][3:0];
        if (pkt_pos >= pkt_len) begin
            pkt_pos = 0;
            has_res = 1'b1;
            if (pkt_buf[0][3:2] == TS_MODE_RSVD) begin
                r.status = ST_RSVD_TS;
                dropping = !lst;
                return;
            end
            r.status = ST_OK;
            for (int a = 0; a < 3; a++) begin
                case (cur_kind)
                    KIND_ACCEL: r.acc[a] = axis16(1 + 2*a);
                    KIND_GYRO:  r.gyr[a] = axis16(1 + 2*a);
                    KIND_BOTH: begin
                        r.acc[a] = axis16(1 + 2*a);
                        r.gyr[a] = axis16(7 + 2*a);
                    end
                    default: begin
                        ext = pkt_buf[17 + a];
                        r.acc[a] = axis20(1 + 2*a, ext[7:4]);
                        r.gyr[a] = axis20(7 + 2*a, ext[3:0]);
                    end
                endcase
            end
            case (cur_kind)
                KIND_ACCEL, KIND_GYRO: r.temp = temp8(7);
                KIND_BOTH: begin
                    r.temp = temp8(13);
                    r.ts = be16(14);
                end
                default: begin
                    r.temp = be16(13);
                    r.ts = be16(15);
                end
            endcase
        end else if (lst) begin
            r.status = ST_TRUNC;
            pkt_pos = 0;
            has_res = 1'b1;
        end
    endtask

    // entered and left at a falling edge
    task automatic push_byte(input logic [7:0] d, input logic lst,
                             input bit typed, input imu_res_t typed_res);
        bit has_res;
        imu_res_t r;
        while (!quiet_phase() && $urandom_range(99) < 18) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = d;
        s_tlast = lst;
        do @(posedge aclk); while (!s_tready);
        parse_byte(d, lst, has_res, r);
        if (typed)
            exp_q.push_back(typed_res);
        else if (has_res)
            exp_q.push_back(r);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic send_burst();
        int sel, n_pk, len, cut_at;
        logic [7:0] hdr;
        logic [1:0] mode;
        logic lst;
        sel = $urandom_range(99);
        if (sel < 3) begin
            push_byte(rnd_byte(), 1'($urandom_range(1)), 1'b0, '0);
            return;
        end
        if (sel < 9) begin
            case ($urandom_range(3))
                0: hdr = {1'b1, 7'($urandom)};
                1: hdr = {3'b000, 5'($urandom)};
                2: hdr = {4'b0101, 4'($urandom)};
                default: hdr = {4'b0011, 4'($urandom)};
            endcase
            lst = 1'($urandom_range(1));
            push_byte(hdr, lst, 1'b0, '0);
            if (!lst) begin
                repeat ($urandom_range(3)) push_byte(rnd_byte(), 1'b0, 1'b0, '0);
                push_byte(rnd_byte(), 1'b1, 1'b0, '0);
            end
            return;
        end
        n_pk = $urandom_range(1, 4);
        for (int p = 0; p < n_pk; p++) begin
            if ($urandom_range(99) < 8) begin
                mode = TS_MODE_RSVD;
            end else begin
                mode = 2'($urandom_range(2));
                if (mode == TS_MODE_RSVD)
                    mode = 2'b11;
            end
            case ($urandom_range(3))
                KIND_ACCEL: hdr = 8'h40;
                KIND_GYRO:  hdr = 8'h20;
                KIND_BOTH:  hdr = 8'h60;
                default:    hdr = 8'h70;
            endcase
            hdr[3:0] = {mode, 2'($urandom)};
            len = 32'(hdr[4] ? LEN_LONG : (hdr[6] && hdr[5]) ? LEN_MID : LEN_SHORT);
            cut_at = (sel < 17 && p == n_pk - 1) ? $urandom_range(len - 2) : len - 1;
            for (int i = 0; i <= cut_at; i++) begin
                lst = (p == n_pk - 1) && (i == cut_at);
                push_byte((i == 0) ? hdr : rnd_byte(), lst, 1'b0, '0);
            end
        end
    endtask

    initial begin
        bit paused;
        imu_res_t tr;
        paused = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        foreach (dir_tab[k]) begin
            tr = '0;
            tr.status = dir_tab[k].status;
            tr.kind = dir_tab[k].kind;
            tr.flags = dir_tab[k].flags;
            push_byte(dir_tab[k].data, dir_tab[k].last, dir_tab[k].typed, tr);
        end
        while (n_parsed < 2000) begin
            if (!paused && n_parsed >= 1500) begin
                paused = 1'b1;
                s_tvalid = 1'b0;
                while (exp_q.size() != 0) @(negedge aclk);
            end
            send_burst();
        end
        s_tvalid = 1'b0;
        while (exp_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (n_err == 0 && exp_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // sink: random back-pressure plus one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && n_sent >= 1000) begin
                held = 1'b1;
                m_tready = 1'b0;
                repeat (300) @(negedge aclk);
            end else begin
                m_tready = quiet_phase() || ($urandom_range(99) >= 18);
            end
        end
    end

    always @(posedge aclk) begin : res_mon
        imu_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_q.size() == 0) begin
                flag_mismatch("unexpected item", longint'(m_tuser), 0);
            end else begin
                want = exp_q.pop_front();
                if (m_tuser[1:0] !== want.status)
                    flag_mismatch("status", longint'(m_tuser[1:0]), longint'(want.status));
                if (m_tuser[3:2] !== want.kind)
                    flag_mismatch("packet_kind", longint'(m_tuser[3:2]), longint'(want.kind));
                for (int a = 0; a < 3; a++) begin
                    if (m_tdata[20*a +: 20] !== want.acc[a])
                        flag_mismatch($sformatf("accel[%0d]", a),
                                      longint'(m_tdata[20*a +: 20]), longint'(want.acc[a]));
                    if (m_tdata[60 + 20*a +: 20] !== want.gyr[a])
                        flag_mismatch($sformatf("gyro[%0d]", a),
                                      longint'(m_tdata[60 + 20*a +: 20]),
                                      longint'(want.gyr[a]));
                end
                if (m_tdata[135:120] !== want.temp)
                    flag_mismatch("temperature_raw", longint'(m_tdata[135:120]),
                                  longint'(want.temp));
                if (m_tdata[151:136] !== want.ts)
                    flag_mismatch("timestamp", longint'(m_tdata[151:136]), longint'(want.ts));
                if (m_tdata[155:152] !== want.flags)
                    flag_mismatch("header_flags", longint'(m_tdata[155:152]),
                                  longint'(want.flags));
            end
        end
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
